// ===== rtl/adsr_pkg.sv =====
package adsr_pkg;

    localparam int TIME_W = 32;
    localparam int LVL_W  = 16;
    localparam int OP_W   = 2;
    localparam int IDX_W  = 3;
    localparam int PROD_W = TIME_W + LVL_W;
    localparam int CNT_W  = $clog2(PROD_W + 1);

    localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OP_W-1:0] OP_GATE_ON  = 2'd1;
    localparam logic [OP_W-1:0] OP_GATE_OFF = 2'd2;

    localparam logic [IDX_W-1:0] REG_ATTACK  = 3'd0;
    localparam logic [IDX_W-1:0] REG_DECAY   = 3'd1;
    localparam logic [IDX_W-1:0] REG_RELEASE = 3'd2;
    localparam logic [IDX_W-1:0] REG_PEAK    = 3'd3;
    localparam logic [IDX_W-1:0] REG_SUSTAIN = 3'd4;

    localparam logic [LVL_W-1:0] PEAK_RST    = 16'hFFFF;
    localparam logic [LVL_W-1:0] SUSTAIN_RST = 16'h8000;

    typedef enum logic [2:0] {
        PH_OFF     = 3'd0,
        PH_START   = 3'd1,
        PH_ATTACK  = 3'd2,
        PH_DECAY   = 3'd3,
        PH_SUSTAIN = 3'd4,
        PH_RELTRIG = 3'd5,
        PH_RELEASE = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WAIT,
        ST_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_state_t;

    typedef enum logic [1:0] {
        LM_ATTACK,
        LM_DECAY_UP,
        LM_DECAY_DN,
        LM_RELEASE
    } lvl_mode_t;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] mcand;
        logic [LVL_W-1:0]  mplier;
        logic [LVL_W-1:0]  divisor;
    } md_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } md_rsp_t;

endpackage

// ===== rtl/adsr_in_if.sv =====
interface adsr_in_if import adsr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [TIME_W-1:0] now;

    modport source (output valid, output opcode, output now, input ready);
    modport sink (input valid, input opcode, input now, output ready);
endinterface

// ===== rtl/adsr_out_if.sv =====
interface adsr_out_if import adsr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LVL_W-1:0] level;
    logic             idle;

    modport source (output valid, output level, output idle, input ready);
    modport sink (input valid, input level, input idle, output ready);
endinterface

// ===== rtl/adsr_cfg_if.sv =====
interface adsr_cfg_if import adsr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [LVL_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/adsr_muldiv.sv =====
module adsr_muldiv import adsr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  md_req_t req,
    output md_rsp_t rsp
);

    localparam logic [CNT_W-1:0] DIV_SHORT = CNT_W'(TIME_W);
    localparam logic [CNT_W-1:0] DIV_LONG  = CNT_W'(PROD_W);

    md_state_t         state_reg, state_next;
    logic [TIME_W-1:0] mcand_reg, mcand_next;
    logic [LVL_W-1:0]  mplier_reg, mplier_next;
    logic [LVL_W-1:0]  divisor_reg, divisor_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [LVL_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;

    logic [PROD_W-1:0] product;
    logic [LVL_W:0]    shifted;
    logic [LVL_W:0]    diff;
    logic              fits;

    assign product = PROD_W'(mcand_reg) * PROD_W'(mplier_reg);
    assign shifted = {rem_reg, quo_reg[PROD_W-1]};
    assign diff    = shifted - {1'b0, divisor_reg};
    assign fits    = (shifted >= {1'b0, divisor_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        divisor_reg <= divisor_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        divisor_next = divisor_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    mcand_next   = req.mcand;
                    mplier_next  = req.mplier;
                    divisor_next = req.divisor;
                    state_next   = MD_MUL;
                end
            end
            MD_MUL:
            begin
                rem_next = '0;
                if (product[PROD_W-1:TIME_W] == '0)
                begin
                    quo_next = {product[TIME_W-1:0], {LVL_W{1'b0}}};
                    cnt_next = DIV_SHORT;
                end
                else
                begin
                    quo_next = product;
                    cnt_next = DIV_LONG;
                end
                state_next = MD_DIV;
            end
            MD_DIV:
            begin
                rem_next = fits ? diff[LVL_W-1:0] : shifted[LVL_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], fits};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    done_next  = 1'b1;
                    state_next = MD_IDLE;
                end
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/adsr_envelope_generator_unit.sv =====
// channel  dir  words                        handshake
// cmd      in   opcode, now                  valid/ready
// res      out  level, idle                  valid/ready
// cfg      in   index, data                  valid/ready, ready always high
//
// gate commands finish in idle; a tick with a ramp goes evaluate, wait, done;
// the serial divider takes all 48 product bits, or 32 if the top 16 are zero
// a tick that needs no division (sustain, off, zero ramp time) skips the wait
// reset puts the envelope off and the registers at their defaults, no sweep
// a stalled result word holds in the output register; a next command is taken
module adsr_envelope_generator_unit import adsr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    adsr_in_if.sink           cmd,
    adsr_out_if.source        res,
    adsr_cfg_if.sink          cfg
);

    seq_state_t        state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [TIME_W-1:0] stamp_reg, stamp_next;
    logic [TIME_W-1:0] offset_reg, offset_next;
    logic              pending_reg, pending_next;
    logic [TIME_W-1:0] now_reg, now_next;
    lvl_mode_t         mode_reg, mode_next;
    logic [LVL_W-1:0]  rlevel_reg, rlevel_next;
    logic              ridle_reg, ridle_next;
    logic              res_valid_reg, res_valid_next;
    logic [LVL_W-1:0]  res_level_reg, res_level_next;
    logic              res_idle_reg, res_idle_next;

    logic [LVL_W-1:0]  attack_reg, decay_reg, release_reg, peak_reg, sustain_reg;

    md_req_t           md_req;
    md_rsp_t           md_rsp;

    logic [TIME_W-1:0] lt;
    logic [TIME_W-1:0] rel_off;
    logic [TIME_W-1:0] elapsed;
    logic [LVL_W:0]    ad_sum;
    logic [LVL_W-1:0]  dmag;
    logic              dup;
    phase_t            eff_phase;
    logic              attack_hit, decay_zone, decay_hit, sustain_zone, rel_zone, rel_hit;

    adsr_muldiv u_muldiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    // config registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= '0;
            decay_reg   <= '0;
            release_reg <= '0;
            peak_reg    <= PEAK_RST;
            sustain_reg <= SUSTAIN_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_ATTACK:  attack_reg  <= cfg.data;
                REG_DECAY:   decay_reg   <= cfg.data;
                REG_RELEASE: release_reg <= cfg.data;
                REG_PEAK:    peak_reg    <= cfg.data;
                REG_SUSTAIN: sustain_reg <= cfg.data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_OFF;
            stamp_reg     <= '0;
            offset_reg    <= '0;
            pending_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            stamp_reg     <= stamp_next;
            offset_reg    <= offset_next;
            pending_reg   <= pending_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg       <= now_next;
        mode_reg      <= mode_next;
        rlevel_reg    <= rlevel_next;
        ridle_reg     <= ridle_next;
        res_level_reg <= res_level_next;
        res_idle_reg  <= res_idle_next;
    end

    // phase decode for a tick
    assign lt         = now_reg - ((phase_reg == PH_START) ? now_reg : stamp_reg);
    assign eff_phase  = (phase_reg == PH_START) ? PH_ATTACK : phase_reg;
    assign ad_sum     = {1'b0, attack_reg} + {1'b0, decay_reg};
    assign dup        = (sustain_reg >= peak_reg);
    assign dmag       = dup ? (sustain_reg - peak_reg) : (peak_reg - sustain_reg);
    assign rel_zone   = (eff_phase == PH_RELTRIG) || (eff_phase == PH_RELEASE);
    assign rel_off    = (eff_phase == PH_RELTRIG) ? lt : offset_reg;
    assign elapsed    = lt - rel_off;

    assign attack_hit   = (eff_phase == PH_ATTACK) && (lt <= TIME_W'(attack_reg));
    assign decay_zone   = ((eff_phase == PH_ATTACK) && !attack_hit) || (eff_phase == PH_DECAY);
    assign decay_hit    = decay_zone && (lt <= TIME_W'(ad_sum));
    assign sustain_zone = (decay_zone && !decay_hit) || (eff_phase == PH_SUSTAIN);
    assign rel_hit      = rel_zone && (release_reg != '0) && (elapsed <= TIME_W'(release_reg));

    assign cmd.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        stamp_next     = stamp_reg;
        offset_next    = offset_reg;
        pending_next   = pending_reg;
        now_next       = now_reg;
        mode_next      = mode_reg;
        rlevel_next    = rlevel_reg;
        ridle_next     = ridle_reg;
        res_valid_next = res_valid_reg;
        res_level_next = res_level_reg;
        res_idle_next  = res_idle_reg;
        md_req         = '0;

        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    case (cmd.opcode)
                        OP_TICK:
                        begin
                            now_next   = cmd.now;
                            state_next = ST_EVAL;
                        end
                        OP_GATE_ON:
                        begin
                            if (phase_reg == PH_OFF)
                            begin
                                stamp_next   = '0;
                                offset_next  = '0;
                                pending_next = 1'b0;
                                phase_next   = PH_START;
                            end
                        end
                        OP_GATE_OFF:
                        begin
                            if (phase_reg inside {PH_START, PH_ATTACK, PH_DECAY})
                            begin
                                pending_next = 1'b1;
                            end
                            else if (phase_reg == PH_SUSTAIN)
                            begin
                                phase_next = PH_RELTRIG;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_EVAL:
            begin
                ridle_next = 1'b0;
                if (phase_reg == PH_START)
                begin
                    stamp_next = now_reg;
                end
                if (rel_zone)
                begin
                    offset_next = rel_off;
                end
                if (attack_hit)
                begin
                    phase_next = PH_ATTACK;
                    if (attack_reg == '0)
                    begin
                        rlevel_next = peak_reg;
                    end
                    else
                    begin
                        md_req.start   = 1'b1;
                        md_req.mcand   = lt;
                        md_req.mplier  = peak_reg;
                        md_req.divisor = attack_reg;
                        mode_next      = LM_ATTACK;
                    end
                end
                else if (decay_hit)
                begin
                    phase_next = PH_DECAY;
                    if (decay_reg == '0)
                    begin
                        rlevel_next = sustain_reg;
                    end
                    else
                    begin
                        md_req.start   = 1'b1;
                        md_req.mcand   = lt - TIME_W'(attack_reg);
                        md_req.mplier  = dmag;
                        md_req.divisor = decay_reg;
                        mode_next      = dup ? LM_DECAY_UP : LM_DECAY_DN;
                    end
                end
                else if (sustain_zone)
                begin
                    rlevel_next = sustain_reg;
                    if (pending_reg)
                    begin
                        offset_next  = lt;
                        pending_next = 1'b0;
                        phase_next   = PH_RELEASE;
                    end
                    else
                    begin
                        phase_next = PH_SUSTAIN;
                    end
                end
                else if (rel_hit)
                begin
                    phase_next     = PH_RELEASE;
                    md_req.start   = 1'b1;
                    md_req.mcand   = elapsed;
                    md_req.mplier  = sustain_reg;
                    md_req.divisor = release_reg;
                    mode_next      = LM_RELEASE;
                end
                else
                begin
                    phase_next  = PH_OFF;
                    rlevel_next = '0;
                    ridle_next  = 1'b1;
                end
                state_next = md_req.start ? ST_WAIT : ST_DONE;
            end
            ST_WAIT:
            begin
                if (md_rsp.done)
                begin
                    case (mode_reg)
                        LM_ATTACK:   rlevel_next = md_rsp.quotient[LVL_W-1:0];
                        LM_DECAY_UP: rlevel_next = peak_reg + md_rsp.quotient[LVL_W-1:0];
                        LM_DECAY_DN:
                        begin
                            if (md_rsp.quotient > PROD_W'(peak_reg))
                            begin
                                rlevel_next = '0;
                            end
                            else
                            begin
                                rlevel_next = peak_reg - md_rsp.quotient[LVL_W-1:0];
                            end
                        end
                        LM_RELEASE:  rlevel_next = sustain_reg - md_rsp.quotient[LVL_W-1:0];
                        default:     rlevel_next = '0;
                    endcase
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next = 1'b1;
                    res_level_next = rlevel_reg;
                    res_idle_next  = ridle_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.valid = res_valid_reg;
    assign res.level = res_level_reg;
    assign res.idle  = res_idle_reg;

endmodule

// ===== rtl/adsr_chk.sv =====
module adsr_chk import adsr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_ready,
    input logic [OP_W-1:0]   cmd_opcode,
    input logic              res_valid,
    input logic              res_ready,
    input logic [LVL_W-1:0]  res_level,
    input logic              res_idle
);

    logic cmd_acc;

    assign cmd_acc = cmd_valid && cmd_ready;

    // a tick keeps the command side busy while it is evaluated
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_acc && cmd_opcode == OP_TICK) |=> !cmd_ready ##1 !cmd_ready)
        else $error("command taken during tick evaluation");

    // gate commands produce no result word
    a_gate_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_acc && cmd_opcode != OP_TICK) |=> !$rose(res_valid))
        else $error("result word after gate command");

    // an ended envelope reports zero level
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_idle) |-> (res_level == '0))
        else $error("idle result with nonzero level");

    // stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=>
            (res_valid && $stable(res_level) && $stable(res_idle)))
        else $error("result word changed under stall");

endmodule

bind adsr_envelope_generator_unit adsr_chk u_adsr_chk
(
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .cmd_opcode (cmd.opcode),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_level  (res.level),
    .res_idle   (res.idle)
);

// ===== test/adsr_envelope_generator_unit_tb.sv =====
module adsr_envelope_generator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import adsr_pkg::*;

    localparam logic [IDX_W-1:0] REG_NONE = 3'd7;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 4000;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic             idle;
    } env_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    adsr_in_if  cmd();
    adsr_out_if res();
    adsr_cfg_if cfg();

    adsr_envelope_generator_unit dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res),
        .cfg   (cfg)
    );

    // register copies
    logic [LVL_W-1:0] attack_len  = '0;
    logic [LVL_W-1:0] decay_len   = '0;
    logic [LVL_W-1:0] release_len = '0;
    logic [LVL_W-1:0] peak_lvl    = PEAK_RST;
    logic [LVL_W-1:0] sustain_lvl = SUSTAIN_RST;

    // envelope state copy
    phase_t            env_phase    = PH_OFF;
    logic [TIME_W-1:0] env_start    = '0;
    logic [TIME_W-1:0] env_rel_ofs  = '0;
    logic              env_rel_pend = 1'b0;

    env_word_t envelope_words[$];
    env_word_t oldest_word;

    int  mismatch_count = 0;
    int  tick_count     = 0;
    int  quiet_cycles   = 0;
    int  hold_left      = 0;
    int  gap_pct        = 0;
    int  stall_pct      = 0;
    bit  hold_req       = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [LVL_W-1:0] envelope_level(input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] lt;
        logic [TIME_W-1:0] el;
        logic [63:0]       q;
        longint            v;
        lt = t - env_start;
        if (env_phase == PH_START)
        begin
            env_start = t;
            lt = '0;
            env_phase = PH_ATTACK;
        end
        if (env_phase == PH_ATTACK)
        begin
            if (lt <= TIME_W'(attack_len))
            begin
                if (attack_len == 0)
                    return peak_lvl;
                q = 64'(lt) * 64'(peak_lvl) / 64'(attack_len);
                return q[LVL_W-1:0];
            end
            env_phase = PH_DECAY;
        end
        if (env_phase == PH_DECAY)
        begin
            if (64'(lt) <= 64'(attack_len) + 64'(decay_len))
            begin
                if (decay_len == 0)
                    return sustain_lvl;
                v = longint'(lt - TIME_W'(attack_len))
                    * (longint'(sustain_lvl) - longint'(peak_lvl))
                    / longint'(decay_len) + longint'(peak_lvl);
                if (v < 0)
                    return '0;
                return v[LVL_W-1:0];
            end
            env_phase = PH_SUSTAIN;
        end
        if (env_phase == PH_SUSTAIN)
        begin
            // gate released early: release starts once sustain is reached
            if (env_rel_pend)
            begin
                env_rel_ofs = lt;
                env_rel_pend = 1'b0;
                env_phase = PH_RELEASE;
            end
            return sustain_lvl;
        end
        if (env_phase == PH_RELTRIG)
        begin
            env_rel_ofs = lt;
            env_phase = PH_RELEASE;
        end
        if (env_phase == PH_RELEASE && release_len != 0)
        begin
            el = lt - env_rel_ofs;
            if (el <= TIME_W'(release_len))
            begin
                q = 64'(el) * 64'(sustain_lvl) / 64'(release_len);
                return sustain_lvl - q[LVL_W-1:0];
            end
        end
        env_phase = PH_OFF;
        return '0;
    endfunction

    function automatic void predict_command(input logic [OP_W-1:0] op,
                                            input logic [TIME_W-1:0] t);
        env_word_t w;
        case (op)
            OP_GATE_ON:
            begin
                if (env_phase == PH_OFF)
                begin
                    env_start = '0;
                    env_rel_ofs = '0;
                    env_rel_pend = 1'b0;
                    env_phase = PH_START;
                end
            end
            OP_GATE_OFF:
            begin
                if (env_phase == PH_START || env_phase == PH_ATTACK || env_phase == PH_DECAY)
                    env_rel_pend = 1'b1;
                else if (env_phase == PH_SUSTAIN)
                    env_phase = PH_RELTRIG;
            end
            OP_TICK:
            begin
                w.level = envelope_level(t);
                w.idle = (env_phase == PH_OFF);
                envelope_words.push_back(w);
                tick_count++;
            end
            default: ;
        endcase
    endfunction

    function automatic void apply_reg(input logic [IDX_W-1:0] idx, input logic [LVL_W-1:0] val);
        case (idx)
            REG_ATTACK:  attack_len = val;
            REG_DECAY:   decay_len = val;
            REG_RELEASE: release_len = val;
            REG_PEAK:    peak_lvl = val;
            REG_SUSTAIN: sustain_lvl = val;
            default: ;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] random_op();
        case ($urandom_range(0, 2))
            0: return OP_TICK;
            1: return OP_GATE_ON;
            default: return OP_GATE_OFF;
        endcase
    endfunction

    // result word checker
    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            if (envelope_words.size() == 0)
            begin
                $display("%0t: level word with none pending, actual level %h idle %b",
                         $time, res.level, res.idle);
                mismatch_count++;
            end
            else
            begin
                oldest_word = envelope_words.pop_front();
                if (res.level !== oldest_word.level)
                begin
                    $display("%0t: level expected %h actual %h",
                             $time, oldest_word.level, res.level);
                    mismatch_count++;
                end
                if (res.idle !== oldest_word.idle)
                begin
                    $display("%0t: idle expected %b actual %b",
                             $time, oldest_word.idle, res.idle);
                    mismatch_count++;
                end
            end
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            res.ready <= 1'b0;
        end
        else
            res.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd.valid && cmd.ready) || (res.valid && res.ready)
            || (cfg.valid && cfg.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic issue_command(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] t);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            cmd.valid <= 1'b0;
            @(negedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.opcode <= op;
        cmd.now <= t;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        predict_command(op, t);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        cmd.valid <= 1'b0;
        do
            @(negedge clk);
        while (envelope_words.size() != 0);
    endtask

    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_regs(input logic [LVL_W-1:0] att, input logic [LVL_W-1:0] dec,
                              input logic [LVL_W-1:0] rel, input logic [LVL_W-1:0] pk,
                              input logic [LVL_W-1:0] sus, input bit spare);
        logic [IDX_W-1:0] idx [6];
        logic [LVL_W-1:0] val [6];
        idx = '{REG_ATTACK, REG_DECAY, REG_RELEASE, REG_PEAK, REG_SUSTAIN, REG_NONE};
        val = '{att, dec, rel, pk, sus, LVL_W'($urandom)};
        for (int i = 0; i < (spare ? 6 : 5); i++)
        begin
            cfg.valid <= 1'b1;
            cfg.index <= idx[i];
            cfg.data <= val[i];
            @(posedge clk);
            while (!cfg.ready)
                @(posedge clk);
            apply_reg(idx[i], val[i]);
            @(negedge clk);
        end
        cfg.valid <= 1'b0;
    endtask

    task automatic pick_settings();
        logic [LVL_W-1:0] len [3];
        logic [LVL_W-1:0] amp [2];
        int               kind;
        kind = $urandom_range(0, 5);
        foreach (len[i])
        begin
            if (kind == 0)
                len[i] = $urandom_range(0, 1) ? '1 : '0;
            else if (kind == 1)
                len[i] = LVL_W'($urandom);
            else
                len[i] = LVL_W'($urandom_range(0, 12));
        end
        foreach (amp[i])
        begin
            case ($urandom_range(0, 5))
                0: amp[i] = '0;
                1: amp[i] = '1;
                default: amp[i] = LVL_W'($urandom);
            endcase
        end
        write_regs(len[0], len[1], len[2], amp[0], amp[1], $urandom_range(0, 15) == 0);
    endtask

    task automatic play_envelope(input int pause_at);
        logic [TIME_W-1:0] t;
        int                stride;
        int                n;
        int                off_at;
        t = $urandom;
        stride = (int'(attack_len) + int'(decay_len) + int'(release_len)) / 8 + 1;
        n = $urandom_range(6, 24);
        off_at = $urandom_range(0, n + 4);
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3))
                issue_command(random_op(), $urandom);
        issue_command(OP_GATE_ON, $urandom);
        for (int i = 0; i < n; i++)
        begin
            if (i == pause_at)
                wait_drained();
            if (i == off_at)
                issue_command(OP_GATE_OFF, $urandom);
            if ($urandom_range(0, 19) == 0)
                issue_command(random_op(), $urandom);
            t += ($urandom_range(0, 39) == 0) ? $urandom : $urandom_range(0, 2 * stride);
            issue_command(OP_TICK, t);
        end
        // run the envelope out to off
        while (env_phase != PH_OFF)
        begin
            issue_command(OP_GATE_OFF, $urandom);
            t += 32'd70000;
            issue_command(OP_TICK, t);
        end
    endtask

    task automatic test_reset_values();
        issue_command(OP_TICK, 32'h0000_0000);
        issue_command(OP_GATE_OFF, 32'h0000_0000);
        issue_command(OP_GATE_ON, 32'hFFFF_FFFF);
        issue_command(OP_TICK, 32'h8000_0000);
        issue_command(OP_TICK, 32'h8000_0001);
        issue_command(OP_GATE_OFF, 32'h0000_0000);
        issue_command(OP_TICK, 32'h8000_0002);
    endtask

    task automatic test_long_ramps();
        logic [TIME_W-1:0] base;
        wait_idle();
        write_regs('1, '1, '1, '1, '0, 1'b1);
        base = 32'hFFFF_FFF0;
        issue_command(OP_GATE_ON, 32'h0);
        issue_command(OP_TICK, base);
        issue_command(OP_TICK, base + 32'd1);
        issue_command(OP_GATE_OFF, 32'h0);
        issue_command(OP_GATE_ON, 32'h0);
        issue_command(OP_TICK, base + 32'd65535);
        issue_command(OP_TICK, base + 32'd98303);
        issue_command(OP_TICK, base + 32'd131071);
        issue_command(OP_GATE_OFF, 32'h0);
        issue_command(OP_TICK, base + 32'd196606);
        issue_command(OP_TICK, base + 32'd196607);
    endtask

    task automatic test_rising_decay();
        logic [TIME_W-1:0] base;
        wait_idle();
        write_regs(16'd3, 16'd4, 16'd5, 16'd100, 16'd60000, 1'b0);
        base = $urandom;
        issue_command(OP_GATE_ON, 32'h0);
        issue_command(OP_TICK, base);
        issue_command(OP_TICK, base + 32'd2);
        issue_command(OP_TICK, base + 32'd5);
        issue_command(OP_TICK, base + 32'd9);
        issue_command(OP_GATE_OFF, 32'h0);
        issue_command(OP_TICK, base + 32'd10);
        issue_command(OP_TICK, base + 32'd13);
        issue_command(OP_TICK, base + 32'd16);
    endtask

    task automatic test_random_traffic(input int gap, input int stall, input int ticks);
        int first;
        gap_pct = gap;
        stall_pct = stall;
        first = tick_count;
        while (tick_count - first < ticks)
        begin
            wait_idle();
            pick_settings();
            play_envelope($urandom_range(0, 7) == 0 ? $urandom_range(1, 12) : -1);
        end
    endtask

    task automatic test_backpressure();
        logic [TIME_W-1:0] t;
        gap_pct = 0;
        stall_pct = 0;
        wait_idle();
        write_regs(16'd8, 16'd8, 16'd8, '1, 16'h4000, 1'b0);
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
        t = $urandom;
        issue_command(OP_GATE_ON, $urandom);
        repeat (30)
        begin
            issue_command(OP_TICK, t);
            t++;
        end
        issue_command(OP_GATE_OFF, $urandom);
        repeat (12)
        begin
            issue_command(OP_TICK, t);
            t++;
        end
    endtask

    task automatic test_sender_pause();
        gap_pct = 27;
        stall_pct = 27;
        wait_idle();
        write_regs(16'd5, 16'd5, 16'd5, 16'hC000, 16'h3000, 1'b0);
        play_envelope(4);
    endtask

    initial
    begin
        cmd.valid = 1'b0;
        cmd.opcode = OP_TICK;
        cmd.now = '0;
        cfg.valid = 1'b0;
        cfg.index = REG_ATTACK;
        cfg.data = '0;
        res.ready = 1'b0;
        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;
        test_reset_values();
        test_long_ramps();
        test_rising_decay();
        test_random_traffic(0, 0, 70);
        test_random_traffic(74, 0, 70);
        test_random_traffic(0, 74, 70);
        test_random_traffic(27, 27, 70);
        test_backpressure();
        test_sender_pause();
        wait_idle();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
